// ===== rtl/xxh_pkg.sv =====
package xxh_pkg;

    localparam int LEN_W = 64;

    localparam logic [63:0] PRIME1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] PRIME3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] PRIME4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4_EB2F_1656_67C5;

    localparam logic [63:0] LANE0_INIT = PRIME1 + PRIME2;
    localparam logic [63:0] LANE1_INIT = PRIME2;
    localparam logic [63:0] LANE2_INIT = 64'd0;
    localparam logic [63:0] LANE3_INIT = 64'd0 - PRIME1;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } item_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
        rotl64 = (v << r) | (v >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

// ===== rtl/xxh_front.sv =====
module xxh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        data_bytes,
    input  logic [3:0]         byte_count,
    input  logic               last,
    output logic               q_valid,
    output xxh_pkg::item_t     q_item,
    input  logic               q_pop
);

    xxh_pkg::item_t slot_reg [2];
    logic           head_reg, head_next;
    logic [1:0]     fill_reg, fill_next;
    xxh_pkg::item_t cls;
    logic           push;

    always_comb
    begin
        cls.cnt  = (byte_count > 4'd8) ? 4'd8 : byte_count;
        cls.last = last;
        for (int i = 0; i < 8; i++)
        begin
            cls.data[8*i +: 8] = (4'(i) < cls.cnt) ? data_bytes[8*i +: 8] : 8'd0;
        end
    end

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[head_reg];

    always_comb
    begin
        head_next = head_reg ^ (q_pop && q_valid);
        fill_next = fill_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[head_reg ^ fill_reg[0]] <= cls;
        end
    end

endmodule

// ===== rtl/xxh_mul.sv =====
module xxh_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        run_reg, run_next, done_reg, done_next;
    logic [31:0] ma, mb;
    logic [63:0] mp;

    always_comb
    begin
        ma = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        mb = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
        mp = ma * mb;
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (run_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_next = mp;
            end
            else
            begin
                acc_next = {acc_reg[63:32] + mp[31:0], acc_reg[31:0]};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start)
        begin
            run_next  = 1'b1;
            step_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/xxh_back.sv =====
module xxh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  xxh_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [63:0]    hash_value
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LANE_A = 5'd1;
    localparam logic [4:0] S_LANE_B = 5'd2;
    localparam logic [4:0] S_FIN    = 5'd3;
    localparam logic [4:0] S_MRG_A  = 5'd4;
    localparam logic [4:0] S_MRG_B  = 5'd5;
    localparam logic [4:0] S_MRG_C  = 5'd6;
    localparam logic [4:0] S_LEN    = 5'd7;
    localparam logic [4:0] S_W8_A   = 5'd8;
    localparam logic [4:0] S_W8_B   = 5'd9;
    localparam logic [4:0] S_W8_C   = 5'd10;
    localparam logic [4:0] S_W4_A   = 5'd11;
    localparam logic [4:0] S_W4_B   = 5'd12;
    localparam logic [4:0] S_B1_A   = 5'd13;
    localparam logic [4:0] S_B1_B   = 5'd14;
    localparam logic [4:0] S_AV1    = 5'd15;
    localparam logic [4:0] S_AV2    = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0]  state_reg, state_next;
    logic [63:0] lane_reg [4];
    logic [63:0] lane_next [4];
    logic [63:0] wbuf_reg [4];
    logic [1:0]  wcnt_reg, wcnt_next;
    logic [63:0] abuf_reg, abuf_next;
    logic [2:0]  acnt_reg, acnt_next;
    logic [xxh_pkg::LEN_W-1:0] len_reg, len_next;
    logic        pend_reg, pend_next;
    logic [1:0]  idx_reg, idx_next;
    logic [63:0] r_reg, r_next, t_reg, t_next;
    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;

    logic        is_mul, mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;
    logic [127:0] comb;
    logic [4:0]  tot;
    logic        wr_word;
    logic [1:0]  wr_idx;
    logic [63:0] wr_data;
    logic        emit;

    xxh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    function automatic logic [4:0] tail_state(input logic [2:0] n);
        if (n >= 3'd4)
        begin
            tail_state = S_W4_A;
        end
        else if (n != 3'd0)
        begin
            tail_state = S_B1_A;
        end
        else
        begin
            tail_state = S_AV1;
        end
    endfunction

    always_comb
    begin
        is_mul = 1'b1;
        mul_a  = 64'd0;
        mul_b  = 64'd0;
        unique case (state_reg)
            S_LANE_A:
            begin
                mul_a = wbuf_reg[idx_reg];
                mul_b = xxh_pkg::PRIME2;
            end
            S_LANE_B:
            begin
                mul_a = xxh_pkg::rotl64(lane_reg[idx_reg] + t_reg, 6'd31);
                mul_b = xxh_pkg::PRIME1;
            end
            S_MRG_A:
            begin
                mul_a = lane_reg[idx_reg];
                mul_b = xxh_pkg::PRIME2;
            end
            S_MRG_B, S_W8_B:
            begin
                mul_a = xxh_pkg::rotl64(t_reg, 6'd31);
                mul_b = xxh_pkg::PRIME1;
            end
            S_MRG_C:
            begin
                mul_a = r_reg ^ t_reg;
                mul_b = xxh_pkg::PRIME1;
            end
            S_W8_A:
            begin
                mul_a = wbuf_reg[idx_reg];
                mul_b = xxh_pkg::PRIME2;
            end
            S_W8_C:
            begin
                mul_a = xxh_pkg::rotl64(r_reg ^ t_reg, 6'd27);
                mul_b = xxh_pkg::PRIME1;
            end
            S_W4_A:
            begin
                mul_a = {32'd0, abuf_reg[31:0]};
                mul_b = xxh_pkg::PRIME1;
            end
            S_W4_B:
            begin
                mul_a = xxh_pkg::rotl64(r_reg ^ t_reg, 6'd23);
                mul_b = xxh_pkg::PRIME2;
            end
            S_B1_A:
            begin
                mul_a = {56'd0, abuf_reg[7:0]};
                mul_b = xxh_pkg::PRIME5;
            end
            S_B1_B:
            begin
                mul_a = xxh_pkg::rotl64(r_reg ^ t_reg, 6'd11);
                mul_b = xxh_pkg::PRIME1;
            end
            S_AV1:
            begin
                mul_a = r_reg ^ (r_reg >> 33);
                mul_b = xxh_pkg::PRIME2;
            end
            S_AV2:
            begin
                mul_a = r_reg ^ (r_reg >> 29);
                mul_b = xxh_pkg::PRIME3;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !busy_reg && !mul_done;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign emit      = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        wcnt_next      = wcnt_reg;
        abuf_next      = abuf_reg;
        acnt_next      = acnt_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        busy_next      = (busy_reg || mul_start) && !mul_done;
        out_valid_next = out_valid_reg && out_stall;
        hash_next      = hash_reg;
        wr_word        = 1'b0;
        wr_idx         = wcnt_reg;
        wr_data        = 64'd0;
        comb = {64'd0, abuf_reg} | ({64'd0, q_item.data} << {acnt_reg, 3'b000});
        tot  = {2'd0, acnt_reg} + {1'b0, q_item.cnt};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    len_next = len_reg + xxh_pkg::LEN_W'(q_item.cnt);
                    if (tot >= 5'd8)
                    begin
                        abuf_next = comb[127:64];
                        acnt_next = 3'(tot - 5'd8);
                        wr_word   = 1'b1;
                        wr_data   = comb[63:0];
                    end
                    else
                    begin
                        abuf_next = comb[63:0];
                        acnt_next = tot[2:0];
                    end
                    if (tot >= 5'd8 && wcnt_reg == 2'd3)
                    begin
                        pend_next  = q_item.last;
                        idx_next   = 2'd0;
                        state_next = S_LANE_A;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + 2'(tot >= 5'd8);
                        if (q_item.last)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_LANE_A, S_MRG_A, S_MRG_B, S_W8_A, S_W8_B, S_W4_A, S_B1_A:
            begin
                if (mul_done)
                begin
                    t_next     = mul_p;
                    state_next = state_reg + 5'd1;
                end
            end
            S_LANE_B:
            begin
                if (mul_done)
                begin
                    lane_next[idx_reg] = mul_p;
                    idx_next           = idx_reg + 2'd1;
                    state_next         = S_LANE_A;
                    if (idx_reg == 2'd3)
                    begin
                        wcnt_next  = 2'd0;
                        state_next = pend_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                idx_next = 2'd0;
                if (len_reg >= xxh_pkg::LEN_W'(32))
                begin
                    r_next = xxh_pkg::rotl64(lane_reg[0], 6'd1)
                           + xxh_pkg::rotl64(lane_reg[1], 6'd7)
                           + xxh_pkg::rotl64(lane_reg[2], 6'd12)
                           + xxh_pkg::rotl64(lane_reg[3], 6'd18);
                    state_next = S_MRG_A;
                end
                else
                begin
                    r_next     = xxh_pkg::PRIME5;
                    state_next = S_LEN;
                end
            end
            S_MRG_C:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p + xxh_pkg::PRIME4;
                    idx_next   = idx_reg + 2'd1;
                    state_next = (idx_reg == 2'd3) ? S_LEN : S_MRG_A;
                end
            end
            S_LEN:
            begin
                r_next     = r_reg + 64'(len_reg);
                idx_next   = 2'd0;
                state_next = (wcnt_reg != 2'd0) ? S_W8_A : tail_state(acnt_reg);
            end
            S_W8_C:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p + xxh_pkg::PRIME4;
                    idx_next   = idx_reg + 2'd1;
                    state_next = (idx_reg == wcnt_reg - 2'd1) ? tail_state(acnt_reg)
                                                              : S_W8_A;
                end
            end
            S_W4_B:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p + xxh_pkg::PRIME3;
                    abuf_next  = abuf_reg >> 32;
                    acnt_next  = acnt_reg - 3'd4;
                    state_next = tail_state(acnt_reg - 3'd4);
                end
            end
            S_B1_B:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p;
                    abuf_next  = abuf_reg >> 8;
                    acnt_next  = acnt_reg - 3'd1;
                    state_next = tail_state(acnt_reg - 3'd1);
                end
            end
            S_AV1:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p;
                    state_next = S_AV2;
                end
            end
            S_AV2:
            begin
                if (mul_done)
                begin
                    r_next     = mul_p;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = r_reg ^ (r_reg >> 32);
                    lane_next[0]   = xxh_pkg::LANE0_INIT;
                    lane_next[1]   = xxh_pkg::LANE1_INIT;
                    lane_next[2]   = xxh_pkg::LANE2_INIT;
                    lane_next[3]   = xxh_pkg::LANE3_INIT;
                    wcnt_next      = 2'd0;
                    abuf_next      = 64'd0;
                    acnt_next      = 3'd0;
                    len_next       = '0;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg[0]   <= xxh_pkg::LANE0_INIT;
            lane_reg[1]   <= xxh_pkg::LANE1_INIT;
            lane_reg[2]   <= xxh_pkg::LANE2_INIT;
            lane_reg[3]   <= xxh_pkg::LANE3_INIT;
            wcnt_reg      <= 2'd0;
            abuf_reg      <= 64'd0;
            acnt_reg      <= 3'd0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            wcnt_reg      <= wcnt_next;
            abuf_reg      <= abuf_next;
            acnt_reg      <= acnt_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        t_reg    <= t_next;
        hash_reg <= hash_next;
        if (wr_word)
        begin
            wbuf_reg[wr_idx] <= wr_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !busy_reg)
        else $error("Multiplier started while a product was pending.");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> busy_reg)
        else $error("Multiplier finished with no request pending.");
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (len_reg == '0) && (acnt_reg == 3'd0) && (wcnt_reg == 2'd0)
                 && out_valid_reg && (state_reg == S_IDLE))
        else $error("State not restored after a digest was issued.");
`endif

endmodule

// ===== rtl/xxh64_stream_hash.sv =====
// Channel  Handshake             Payload
// input    in_valid / in_stall   data_bytes[63:0], byte_count[3:0], last
// output   out_valid / out_stall hash_value[63:0]
//
// A word that does not complete a stripe is only buffered by the core, unless it is the last word.
// A completed stripe adds four lane rounds of two 64-bit products each, and every
// product is formed on the one shared 32x32 multiplier.
// Finalization takes 2 to 31 products on the same multiplier.
// A two-word input queue and the result register let each side stall on its own.
// Reset is asynchronous and active low; no clearing pass is needed.
module xxh64_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    logic           q_valid, q_pop;
    xxh_pkg::item_t q_item;

    xxh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .last       (last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    xxh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule
